### rtl/torus_neighbor_rank_generator_core_defines.svh
// Assertion macros for the torus neighbor rank generator.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef TORUS_NEIGHBOR_RANK_GENERATOR_CORE_DEFINES_SVH
`define TORUS_NEIGHBOR_RANK_GENERATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TNRG_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
`define TNRG_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define TNRG_ASSERT_IMP(label, clk, rst, pre, post, msg)
`define TNRG_ASSERT_NXT(label, clk, rst, pre, post, msg)
`endif

`endif

### rtl/tnrg_pkg.sv
// Shared constants and types for the torus neighbor rank generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tnrg_pkg;

   localparam int RANK_W     = 16;  // node and neighbor rank width
   localparam int DIM_W      = 3;   // dim_count register width
   localparam int SIDE_REG_W = 5;   // side_len register width
   localparam int SLOT_W     = 3;   // neighbor slot width
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int HALF_STEPS = RANK_W / 2;  // quotient bits per divider cycle

   localparam logic [DIM_W-1:0]      DIM_RESET  = 3'd2;
   localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 5'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIM_COUNT = 2'd0,
      CSR_SIDE_LEN  = 2'd1
   } csr_index_type;

endpackage

`default_nettype wire

### rtl/tnrg_front.sv
// Front end: accepts a node rank and splits it into mixed-radix digits with an
// eight-bit-per-cycle restoring divider; pushes digits and weights to the queue, waiting while it is full.
// Depends on tnrg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tnrg_front #(
   parameter int MAX_SIDE = 16,
   parameter int MAX_DIMS = 4,
   localparam int DIGIT_W = $clog2(MAX_SIDE),
   localparam int SIDE_W  = DIGIT_W + 1,
   localparam int CW      = $clog2(MAX_DIMS),
   localparam int ENTRY_W = 3 * tnrg_pkg::RANK_W + MAX_DIMS * (DIGIT_W + 2 * tnrg_pkg::RANK_W)
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   output logic                            busy,
   input  wire  [tnrg_pkg::RANK_W-1:0]     req_node_rank,
   input  wire  [SIDE_W-1:0]               eff_side,
   input  wire  [tnrg_pkg::DIM_W-1:0]      eff_dims,
   input  wire                             q_full,
   output logic                            q_push,
   output logic [ENTRY_W-1:0]              q_wdata
);

   localparam int RW  = tnrg_pkg::RANK_W;
   localparam int SEG = DIGIT_W + 2 * RW;

   logic              act_ff, act_in;
   logic              phase_ff, phase_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [RW-1:0]     dq_ff, dq_in;
   logic [SIDE_W-1:0] r_ff, r_in;
   logic [RW-1:0]     rank_ff, rank_in;
   logic [RW-1:0]     w_ff, w_in;
   logic [RW-1:0]     wn_ff, wn_in;

   logic [DIGIT_W-1:0] dig_ff [MAX_DIMS];
   logic [DIGIT_W-1:0] dig_in [MAX_DIMS];
   logic [RW-1:0]      wt_ff  [MAX_DIMS];
   logic [RW-1:0]      wt_in  [MAX_DIMS];
   logic [RW-1:0]      wm_ff  [MAX_DIMS];
   logic [RW-1:0]      wm_in  [MAX_DIMS];

   logic [RW-1:0]     dq_v;
   logic [SIDE_W-1:0] r_v;
   logic [SIDE_W:0]   rx;
   logic [RW-1:0]     wn_mul;
   logic              last_dig;
   logic              advance;
   logic              accept;

   // Eight restoring-division steps on the current half of the dividend.
   always_comb begin
      dq_v = dq_ff;
      r_v  = r_ff;
      rx   = '0;
      for (int i = 0; i < tnrg_pkg::HALF_STEPS; i++) begin
         rx   = {r_v, dq_v[RW-1]};
         dq_v = {dq_v[RW-2:0], 1'b0};
         if (rx >= {1'b0, eff_side}) begin
            rx      = rx - {1'b0, eff_side};
            dq_v[0] = 1'b1;
         end
         r_v = rx[SIDE_W-1:0];
      end
   end

   assign wn_mul   = w_ff * RW'(eff_side);
   assign last_dig = phase_ff && (idx_ff == '0);
   assign q_push   = act_ff && last_dig && !q_full;
   assign advance  = act_ff && (!last_dig || !q_full);
   assign busy     = act_ff && !q_push;
   assign accept   = start && !busy;

   always_comb begin
      act_in   = act_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      dq_in    = dq_ff;
      r_in     = r_ff;
      rank_in  = rank_ff;
      w_in     = w_ff;
      wn_in    = wn_ff;
      dig_in   = dig_ff;
      wt_in    = wt_ff;
      wm_in    = wm_ff;

      if (advance && phase_ff) begin
         dig_in[idx_ff] = DIGIT_W'(r_v);
         wt_in[idx_ff]  = w_ff;
         wm_in[idx_ff]  = wn_ff - w_ff;
      end

      if (accept) begin
         act_in   = 1'b1;
         phase_in = 1'b0;
         idx_in   = CW'(eff_dims - 3'd1);
         dq_in    = req_node_rank;
         r_in     = '0;
         rank_in  = req_node_rank;
         w_in     = RW'(1);
      end else if (advance) begin
         if (!phase_ff) begin
            dq_in    = dq_v;
            r_in     = r_v;
            wn_in    = wn_mul;
            phase_in = 1'b1;
         end else if (last_dig) begin
            act_in = 1'b0;
         end else begin
            // next digit divides the quotient, weight grows by one side
            dq_in    = dq_v;
            r_in     = '0;
            w_in     = wn_ff;
            idx_in   = idx_ff - 1'b1;
            phase_in = 1'b0;
         end
      end
   end

   // Entry: rank, final quotient, side^dims, then digit/weight/weight*(side-1).
   always_comb begin
      q_wdata = '0;
      q_wdata[0 +: RW]      = rank_ff;
      q_wdata[RW +: RW]     = dq_v;
      q_wdata[2 * RW +: RW] = wn_ff;
      for (int k = 0; k < MAX_DIMS; k++) begin
         q_wdata[3 * RW + k * SEG +: DIGIT_W]                = dig_in[k];
         q_wdata[3 * RW + k * SEG + DIGIT_W +: RW]           = wt_in[k];
         q_wdata[3 * RW + k * SEG + DIGIT_W + RW +: RW]      = wm_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         act_ff   <= act_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      dq_ff   <= dq_in;
      r_ff    <= r_in;
      rank_ff <= rank_in;
      w_ff    <= w_in;
      wn_ff   <= wn_in;
      dig_ff  <= dig_in;
      wt_ff   <= wt_in;
      wm_ff   <= wm_in;
   end

endmodule

`default_nettype wire

### rtl/tnrg_fifo.sv
// Two-entry queue between the digit front end and the neighbor emitter.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module tnrg_fifo #(
   parameter int W = 8
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          push,
   input  wire  [W-1:0] wdata,
   input  wire          pop,
   output logic [W-1:0] rdata,
   output logic         full,
   output logic         empty
);

   logic [W-1:0] mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

### rtl/tnrg_back.sv
// Back end: pops one digit entry, rebuilds the node rank and emits one neighbor
// rank per cycle through an output register. Depends on tnrg_pkg and the defines.
`timescale 1ns / 1ps
`default_nettype none
`include "torus_neighbor_rank_generator_core_defines.svh"

module tnrg_back #(
   parameter int MAX_SIDE = 16,
   parameter int MAX_DIMS = 4,
   localparam int DIGIT_W = $clog2(MAX_SIDE),
   localparam int SIDE_W  = DIGIT_W + 1,
   localparam int CW      = $clog2(MAX_DIMS),
   localparam int ENTRY_W = 3 * tnrg_pkg::RANK_W + MAX_DIMS * (DIGIT_W + 2 * tnrg_pkg::RANK_W)
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire  [SIDE_W-1:0]               eff_side,
   input  wire  [tnrg_pkg::DIM_W-1:0]      eff_dims,
   input  wire                             q_empty,
   input  wire  [ENTRY_W-1:0]              q_rdata,
   output logic                            q_pop,
   output logic                            rsp_valid,
   output logic [tnrg_pkg::SLOT_W-1:0]     rsp_neighbor_slot,
   output logic [tnrg_pkg::RANK_W-1:0]     rsp_neighbor_rank,
   output logic                            rsp_last
);

   localparam int RW  = tnrg_pkg::RANK_W;
   localparam int SEG = DIGIT_W + 2 * RW;
   localparam int SW  = tnrg_pkg::SLOT_W;

   logic               it_valid_ff, it_valid_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [RW-1:0]      base_ff, base_in;
   logic [DIGIT_W-1:0] dig_ff [MAX_DIMS];
   logic [DIGIT_W-1:0] dig_in [MAX_DIMS];
   logic [RW-1:0]      wt_ff  [MAX_DIMS];
   logic [RW-1:0]      wt_in  [MAX_DIMS];
   logic [RW-1:0]      wm_ff  [MAX_DIMS];
   logic [RW-1:0]      wm_in  [MAX_DIMS];

   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_slot_ff, rsp_slot_in;
   logic [RW-1:0] rsp_rank_ff, rsp_rank_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [RW-1:0]             h_rank, h_q, h_wt, base_pop;
   logic [tnrg_pkg::DIM_W:0]  two_d;
   logic [SW-1:0]             last_slot;
   logic                      is_last;
   logic [CW-1:0]             coord;
   logic [DIGIT_W-1:0]        d_cur;
   logic [RW-1:0]             w_cur, wm_cur, nbr;

   assign h_rank   = q_rdata[0 +: RW];
   assign h_q      = q_rdata[RW +: RW];
   assign h_wt     = q_rdata[2 * RW +: RW];
   // rank = q * side^dims + base, all modulo 2^16
   assign base_pop = h_rank - h_q * h_wt;

   assign two_d     = {eff_dims, 1'b0};
   assign last_slot = SW'(two_d - 1'b1);
   assign is_last   = (slot_ff == last_slot);
   assign q_pop     = !q_empty && (!it_valid_ff || is_last);

   assign coord  = slot_ff[CW:1];
   assign d_cur  = dig_ff[coord];
   assign w_cur  = wt_ff[coord];
   assign wm_cur = wm_ff[coord];

   // Minus wraps from digit zero to side-1, plus wraps from side-1 to zero.
   always_comb begin
      if (!slot_ff[0]) begin
         nbr = (d_cur == '0) ? base_ff + wm_cur : base_ff - w_cur;
      end else begin
         nbr = ({1'b0, d_cur} == eff_side - 1'b1) ? base_ff - wm_cur : base_ff + w_cur;
      end
   end

   always_comb begin
      it_valid_in = it_valid_ff;
      slot_in     = slot_ff;
      base_in     = base_ff;
      dig_in      = dig_ff;
      wt_in       = wt_ff;
      wm_in       = wm_ff;

      rsp_valid_in = it_valid_ff;
      rsp_slot_in  = slot_ff;
      rsp_rank_in  = nbr;
      rsp_last_in  = is_last;

      if (q_pop) begin
         it_valid_in = 1'b1;
         slot_in     = '0;
         base_in     = base_pop;
         for (int k = 0; k < MAX_DIMS; k++) begin
            dig_in[k] = q_rdata[3 * RW + k * SEG +: DIGIT_W];
            wt_in[k]  = q_rdata[3 * RW + k * SEG + DIGIT_W +: RW];
            wm_in[k]  = q_rdata[3 * RW + k * SEG + DIGIT_W + RW +: RW];
         end
      end else if (it_valid_ff) begin
         if (is_last) begin
            it_valid_in = 1'b0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         it_valid_ff  <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         it_valid_ff  <= it_valid_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      dig_ff      <= dig_in;
      wt_ff       <= wt_in;
      wm_ff       <= wm_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_rank_ff <= rsp_rank_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_neighbor_slot = rsp_slot_ff;
   assign rsp_neighbor_rank = rsp_rank_ff;
   assign rsp_last          = rsp_last_ff;

   `TNRG_ASSERT_NXT(a_burst_continues, clock, reset, rsp_valid && !rsp_last, rsp_valid && (rsp_neighbor_slot == SW'($past(rsp_neighbor_slot) + 1'b1)), "neighbor burst broken")
   `TNRG_ASSERT_NXT(a_next_node_starts, clock, reset, rsp_valid && rsp_last, !rsp_valid || (rsp_neighbor_slot == '0), "new node does not start at slot zero")
   `TNRG_ASSERT_IMP(a_last_on_plus, clock, reset, rsp_valid && !rsp_neighbor_slot[0], !rsp_last, "last flagged on a minus neighbor")

endmodule

`default_nettype wire

### rtl/torus_neighbor_rank_generator_core.sv
// A node's first neighbor reaches the rsp ports via the digit divider, the two-entry
// queue and the emitter's registers; the rest follow one per cycle, 2*D in all
// (D = effective dimension count). A new node is taken as the last is pushed; node rate
// is set by the eight-quotient-bit-per-cycle divider and the one-per-cycle emitter.
// The receiver cannot stall; results are strobed on rsp_valid for one cycle.
// Reset is synchronous: config returns to 2 dimensions, side 4, work in flight is dropped.
`timescale 1ns / 1ps
`default_nettype none

module torus_neighbor_rank_generator_core #(
   parameter int MAX_SIDE = 16,
   parameter int MAX_DIMS = 4
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire  [tnrg_pkg::RANK_W-1:0]        req_node_rank,
   output logic                               rsp_valid,
   output logic [tnrg_pkg::SLOT_W-1:0]        rsp_neighbor_slot,
   output logic [tnrg_pkg::RANK_W-1:0]        rsp_neighbor_rank,
   output logic                               rsp_last,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [tnrg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [tnrg_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DIGIT_W = $clog2(MAX_SIDE);
   localparam int SIDE_W  = DIGIT_W + 1;
   localparam int ENTRY_W = 3 * tnrg_pkg::RANK_W + MAX_DIMS * (DIGIT_W + 2 * tnrg_pkg::RANK_W);

   logic [tnrg_pkg::DIM_W-1:0]      dims_ff, dims_in;
   logic [tnrg_pkg::SIDE_REG_W-1:0] side_ff, side_in;
   logic [tnrg_pkg::DIM_W-1:0]      eff_dims;
   logic [SIDE_W-1:0]               eff_side;

   logic               q_push, q_pop, q_full, q_empty;
   logic [ENTRY_W-1:0] q_wdata, q_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      dims_in = dims_ff;
      side_in = side_ff;
      if (csr_valid) begin
         case (csr_index)
            tnrg_pkg::CSR_DIM_COUNT: dims_in = csr_wdata[tnrg_pkg::DIM_W-1:0];
            tnrg_pkg::CSR_SIDE_LEN:  side_in = csr_wdata[tnrg_pkg::SIDE_REG_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= tnrg_pkg::DIM_RESET;
         side_ff <= tnrg_pkg::SIDE_RESET;
      end else begin
         dims_ff <= dims_in;
         side_ff <= side_in;
      end
   end

   // Clamp the raw registers into the supported range.
   always_comb begin
      if (dims_ff < 3'd2) begin
         eff_dims = 3'd2;
      end else if (32'(dims_ff) > MAX_DIMS) begin
         eff_dims = tnrg_pkg::DIM_W'(MAX_DIMS);
      end else begin
         eff_dims = dims_ff;
      end

      if (side_ff == '0) begin
         eff_side = SIDE_W'(1);
      end else if (32'(side_ff) > MAX_SIDE) begin
         eff_side = SIDE_W'(MAX_SIDE);
      end else begin
         eff_side = SIDE_W'(side_ff);
      end
   end

   tnrg_front #(
      .MAX_SIDE (MAX_SIDE),
      .MAX_DIMS (MAX_DIMS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_node_rank (req_node_rank),
      .eff_side      (eff_side),
      .eff_dims      (eff_dims),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_wdata       (q_wdata)
   );

   tnrg_fifo #(
      .W (ENTRY_W)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   tnrg_back #(
      .MAX_SIDE (MAX_SIDE),
      .MAX_DIMS (MAX_DIMS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .eff_side          (eff_side),
      .eff_dims          (eff_dims),
      .q_empty           (q_empty),
      .q_rdata           (q_rdata),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_neighbor_slot (rsp_neighbor_slot),
      .rsp_neighbor_rank (rsp_neighbor_rank),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

### sim/torus_neighbor_rank_generator_core_tb.sv
`timescale 1ns / 1ps
// Testbench for torus_neighbor_rank_generator_core: directed and random node ranks over
// several torus shapes, each neighbor list predicted here and checked in order.
// Depends on rtl/tnrg_pkg.sv and rtl/torus_neighbor_rank_generator_core.sv.

module torus_neighbor_rank_generator_core_tb;

   localparam int MAX_SIDE    = 16;
   localparam int MAX_DIMS    = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [tnrg_pkg::CSR_IDX_W-1:0] CSR_UNUSED_2 = 2'd2;
   localparam logic [tnrg_pkg::CSR_IDX_W-1:0] CSR_UNUSED_3 = 2'd3;

   typedef struct packed {
      logic [tnrg_pkg::SLOT_W-1:0] slot;
      logic [tnrg_pkg::RANK_W-1:0] rank;
      logic                        last;
   } neighbor_type;

   logic                            clock         = 1'b0;
   logic                            reset         = 1'b1;
   logic                            start         = 1'b0;
   logic [tnrg_pkg::RANK_W-1:0]     req_node_rank = '0;
   logic                            csr_valid     = 1'b0;
   logic [tnrg_pkg::CSR_IDX_W-1:0]  csr_index     = '0;
   logic [tnrg_pkg::CSR_DATA_W-1:0] csr_wdata     = '0;
   wire                             busy;
   wire                             rsp_valid;
   wire  [tnrg_pkg::SLOT_W-1:0]     rsp_neighbor_slot;
   wire  [tnrg_pkg::RANK_W-1:0]     rsp_neighbor_rank;
   wire                             rsp_last;
   wire                             csr_ready;

   // shadow copy of the core's configuration registers
   logic [tnrg_pkg::DIM_W-1:0]      dim_reg  = tnrg_pkg::DIM_RESET;
   logic [tnrg_pkg::SIDE_REG_W-1:0] side_reg = tnrg_pkg::SIDE_RESET;

   logic [tnrg_pkg::RANK_W-1:0] node_rank_q[$];
   neighbor_type                neighbor_q[$];
   int unsigned                 idle_pct    = 0;
   int unsigned                 fail_count  = 0;
   int unsigned                 cycle_count = 0;

   torus_neighbor_rank_generator_core #(
      .MAX_SIDE(MAX_SIDE),
      .MAX_DIMS(MAX_DIMS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_node_rank    (req_node_rank),
      .rsp_valid        (rsp_valid),
      .rsp_neighbor_slot(rsp_neighbor_slot),
      .rsp_neighbor_rank(rsp_neighbor_rank),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int torus_dims();
      if (dim_reg < 2) return 2;
      if (dim_reg > MAX_DIMS) return MAX_DIMS;
      return int'(dim_reg);
   endfunction

   function automatic int torus_side();
      if (side_reg == 0) return 1;
      if (side_reg > MAX_SIDE) return MAX_SIDE;
      return int'(side_reg);
   endfunction

   // Split the rank into digits (last coordinate least significant), then emit the
   // minus-one and plus-one neighbor of every coordinate, most significant first.
   function automatic void predict_neighbors(input logic [tnrg_pkg::RANK_W-1:0] node);
      int           dims;
      int           side;
      int           rest;
      int           w;
      int           base_rank;
      int           without;
      int           k;
      int           digit[MAX_DIMS];
      int           weight[MAX_DIMS];
      neighbor_type n;
      dims      = torus_dims();
      side      = torus_side();
      rest      = int'(node);
      w         = 1;
      base_rank = 0;
      for (k = dims - 1; k >= 0; k--) begin
         digit[k]  = rest % side;
         weight[k] = w;
         rest      = rest / side;
         w         = w * side;
      end
      for (k = 0; k < dims; k++)
         base_rank += digit[k] * weight[k];
      for (k = 0; k < dims; k++) begin
         without = base_rank - digit[k] * weight[k];
         n.slot  = tnrg_pkg::SLOT_W'(2 * k);
         n.rank  = tnrg_pkg::RANK_W'(without + ((digit[k] + side - 1) % side) * weight[k]);
         n.last  = 1'b0;
         neighbor_q.push_back(n);
         n.slot  = tnrg_pkg::SLOT_W'(2 * k + 1);
         n.rank  = tnrg_pkg::RANK_W'(without + ((digit[k] + 1) % side) * weight[k]);
         n.last  = (k == dims - 1);
         neighbor_q.push_back(n);
      end
   endfunction

   // Driver: hold a transaction until the core takes it, then offer the next one.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            predict_neighbors(req_node_rank);
         if (!start || !busy) begin
            if (node_rank_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
               start         <= 1'b1;
               req_node_rank <= node_rank_q.pop_front();
            end else begin
               start         <= 1'b0;
               req_node_rank <= tnrg_pkg::RANK_W'($urandom);
            end
         end
      end
   end

   // Monitor: every strobed neighbor must match the oldest prediction.
   always @(posedge clock) begin
      neighbor_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else if (!reset && rsp_valid) begin
         if (neighbor_q.size() == 0) begin
            $error("unexpected neighbor: slot %0d rank %0d last %0d",
                   rsp_neighbor_slot, rsp_neighbor_rank, rsp_last);
            fail_count++;
         end else begin
            want = neighbor_q.pop_front();
            if (rsp_neighbor_slot !== want.slot) begin
               $error("neighbor_slot: expected %0d, got %0d", want.slot, rsp_neighbor_slot);
               fail_count++;
            end
            if (rsp_neighbor_rank !== want.rank) begin
               $error("neighbor_rank: expected %0d, got %0d", want.rank, rsp_neighbor_rank);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // Sample on the falling edge so the driver's updates from the rising edge are settled.
   task automatic wait_idle();
      @(negedge clock);
      while (node_rank_q.size() != 0 || start || neighbor_q.size() != 0 || busy)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Called at a rising edge; holds csr_valid until the write is taken, then drops it and randomizes index and data.
   task automatic write_csr(input logic [tnrg_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tnrg_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == tnrg_pkg::CSR_DIM_COUNT)
         dim_reg = data[tnrg_pkg::DIM_W-1:0];
      else if (idx == tnrg_pkg::CSR_SIDE_LEN)
         side_reg = data[tnrg_pkg::SIDE_REG_W-1:0];
      csr_valid <= 1'b0;
      csr_index <= tnrg_pkg::CSR_IDX_W'($urandom);
      csr_wdata <= tnrg_pkg::CSR_DATA_W'($urandom);
      @(posedge clock);
   endtask

   task automatic configure(input int dims_val, input int side_val);
      wait_idle();
      // random upper bits exercise the masking of the write data
      write_csr(tnrg_pkg::CSR_DIM_COUNT,
                tnrg_pkg::CSR_DATA_W'(($urandom_range(31) << 3) | dims_val));
      write_csr(tnrg_pkg::CSR_SIDE_LEN,
                tnrg_pkg::CSR_DATA_W'(($urandom_range(7) << 5) | side_val));
   endtask

   initial begin
      int                          phase;
      int                          dims;
      int                          side;
      int                          span;
      int                          pick;
      logic [tnrg_pkg::RANK_W-1:0] rank;
      int                          phase_dims[8];
      int                          phase_side[8];
      int unsigned                 phase_idle[4];

      phase_dims = '{4, 3, 2, 4, 3, 2, 4, 1};
      phase_side = '{16, 3, 1, 5, 16, 2, 7, 17};
      phase_idle = '{0, 58, 0, 24};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset shape: 2-D, side 4
      node_rank_q = '{16'd0, 16'd15, 16'd16, 16'hFFFF, 16'hAAAA, 16'h5555};
      configure(4, 16);
      node_rank_q = '{16'd0, 16'hFFFF, 16'h1234, 16'hFEDC};
      // side one: every neighbor is rank 0
      configure(3, 1);
      node_rank_q = '{16'd0, 16'd7, 16'hFFFF};
      // side two: minus and plus neighbors coincide
      configure(3, 2);
      node_rank_q = '{16'd0, 16'd5, 16'd7, 16'd8};
      // zero dims and zero side clamp up, oversize values clamp down
      configure(0, 0);
      node_rank_q = '{16'h00FF};
      configure(7, 31);
      node_rank_q = '{16'hBEEF, 16'd0};
      // writes to unmapped indexes are dropped
      wait_idle();
      write_csr(CSR_UNUSED_2, 8'hFF);
      write_csr(CSR_UNUSED_3, 8'h00);
      node_rank_q = '{16'h0041};

      for (phase = 0; phase < 8; phase++) begin
         idle_pct = phase_idle[phase % 4];
         if (phase == 7)
            configure($urandom_range(7), $urandom_range(31));
         else
            configure(phase_dims[phase], phase_side[phase]);
         dims = torus_dims();
         side = torus_side();
         span = 1;
         repeat (dims) span = span * side;
         repeat (60) begin
            pick = $urandom_range(9);
            if (pick < 6) begin
               rank = tnrg_pkg::RANK_W'($urandom_range(span - 1));
            end else if (pick < 8) begin
               rank = tnrg_pkg::RANK_W'($urandom);
            end else begin
               case ($urandom_range(3))
                  0: rank = tnrg_pkg::RANK_W'(span - 1);
                  1: rank = tnrg_pkg::RANK_W'(span);
                  2: rank = '0;
                  default: rank = '1;
               endcase
            end
            node_rank_q.push_back(rank);
         end
      end

      wait_idle();
      repeat (12) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
